// ===== design/lrj_pkg.sv =====
// ----------------------------------------------------------------------------
// lrj_pkg : shared types for the landmark range and Jacobian core
// Input and result beat structs, command codes and datapath widths.
// ----------------------------------------------------------------------------
package lrj_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = 25;
  localparam int SqW    = 50;
  localparam int SumW   = 52;
  localparam int RangeW = 25;
  localparam int JacW   = 16;
  localparam int NumW   = 41;  // |d| << 15 fits in 25+15 bits, one spare

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic               command;
    logic [3:0]         slot;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         landmark_index;
    logic [24:0]        range_mm;
    logic signed [15:0] jac_x;
    logic signed [15:0] jac_y;
    logic signed [15:0] jac_z;
    logic               degenerate;
    logic               last;
  } out_beat_t;

  // Control between sequencer and shared divide/root unit
  typedef struct packed {
    logic start_sqrt;
    logic start_div;
  } unit_cmd_t;

endpackage

// ===== design/lrj_unit.sv =====
// ----------------------------------------------------------------------------
// lrj_unit : shared iterative root / divide unit
// Bit-serial restoring square root (26 steps) or divide (16 steps).
// ----------------------------------------------------------------------------
module lrj_unit
  import lrj_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  unit_cmd_t         cmd,
  input  logic [SumW-1:0]   radicand,
  input  logic [NumW-1:0]   numer,
  input  logic [RangeW-1:0] denom,
  output logic              busy,
  output logic [RangeW-1:0] root,
  output logic [16:0]       quot
);

  logic [SumW-1:0]   rem;        // sqrt remainder or divide partial remainder
  logic [SumW-1:0]   src;        // bits still to shift in
  logic [RangeW:0]   acc;        // root or quotient bits
  logic [5:0]        count;
  logic              mode_div;
  logic [RangeW-1:0] dvs;

  logic [SumW-1:0]   rem_sh;
  logic [SumW-1:0]   trial;
  logic              fits;

  always_comb begin
    if (mode_div) begin
      rem_sh = {rem[SumW-2:0], src[SumW-1]};
      trial  = {{(SumW-RangeW){1'b0}}, dvs};
    end else begin
      rem_sh = {rem[SumW-3:0], src[SumW-1:SumW-2]};
      trial  = {{(SumW-RangeW-2){1'b0}}, acc[RangeW-1:0], 2'b01};
    end
    fits = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start_sqrt) begin
      count    <= 6'd26;
      mode_div <= 1'b0;
      rem      <= '0;
      src      <= radicand;
      acc      <= '0;
    end else if (cmd.start_div) begin
      count    <= 6'd16;
      mode_div <= 1'b1;
      rem      <= {{(SumW-RangeW){1'b0}}, numer[NumW-1:16]};
      src      <= {numer[15:0], {(SumW-16){1'b0}}};
      acc      <= '0;
      dvs      <= denom;
      // numerator high part is below denom, so 16 steps give the quotient
    end else if (count != 0) begin
      count <= count - 6'd1;
      rem   <= fits ? rem_sh - trial : rem_sh;
      acc   <= {acc[RangeW-1:0], fits};
      src   <= mode_div ? {src[SumW-2:0], 1'b0} : {src[SumW-3:0], 2'b00};
    end
  end

  assign busy = (count != 0);
  assign root = acc[RangeW-1:0];
  assign quot = acc[16:0];

endmodule

// ===== design/landmark_range_and_jacobian_core.sv =====
// ----------------------------------------------------------------------------
// landmark_range_and_jacobian_core : range and Jacobian row per landmark
// Landmark table, sequencer and one shared root/divide unit.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall / in_data. command 0 loads a landmark
//                 (slot >= LANDMARK_COUNT is dropped), command 1 evaluates.
//   out channel : out_valid / out_stall / out_data, one beat per landmark in
//                 table order, last set on the final one.
// Sequence: a load writes the table while idle. Per landmark: table read,
//   difference, squaring and root start (one multiplier), square root,
//   then three divisions, one per axis, all on the one shared serial
//   unit, and presentation of the result. Division is skipped when the
//   range is zero.
// The core takes no new input beat until all results of the current one
//   are delivered. A result waits in the output register while out_stall
//   is high; the sequencer holds with it.
// Reset (rst, synchronous) returns the sequencer to idle; table contents
//   stay undefined until loaded.
// ----------------------------------------------------------------------------
module landmark_range_and_jacobian_core
  import lrj_pkg::*;
#(
  parameter int LANDMARK_COUNT = 4
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int IdxW = (LANDMARK_COUNT > 1) ? $clog2(LANDMARK_COUNT) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_ROOT = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_OUT  = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;

  logic [3:0] state;

  // landmark table: x,y,z packed
  logic [3*CoordW-1:0] table_mem [LANDMARK_COUNT];
  logic [3*CoordW-1:0] entry;

  in_beat_t                pos;
  logic [IdxW-1:0]         idx;
  logic signed [DiffW-1:0] d [3];
  logic [SumW-1:0]         sum;
  logic [1:0]              axis;
  logic [RangeW-1:0]       range;
  logic signed [JacW-1:0]  jac [3];
  logic                    started;

  unit_cmd_t         ucmd;
  logic              ubusy;
  logic [RangeW-1:0] uroot;
  logic [16:0]       uquot;
  logic [DiffW-1:0]  mag;
  logic signed [DiffW-1:0] dsel;
  logic signed [SqW-1:0]   sq;

  assign dsel = d[axis];
  assign mag  = dsel[DiffW-1] ? DiffW'(-dsel) : DiffW'(dsel);
  assign sq   = dsel * dsel;

  // zero range skips division entirely, so the unit is idle when we return
  always_comb begin
    ucmd.start_sqrt = (state == S_SQ) && (axis == 2'd3);
    ucmd.start_div  = (state == S_DIV) && !started && !ubusy && (range != '0);
  end

  lrj_unit u_unit (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ucmd),
    .radicand (sum),
    .numer    ({1'b0, mag, 15'd0}),
    .denom    (range),
    .busy     (ubusy),
    .root     (uroot),
    .quot     (uquot)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && in_data.command == CMD_LOAD &&
        {1'b0, in_data.slot} < 5'(LANDMARK_COUNT))
      table_mem[in_data.slot[IdxW-1:0]] <= {in_data.coord_x, in_data.coord_y,
                                            in_data.coord_z};
    entry <= table_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_data.command == CMD_EVAL) begin
            pos   <= in_data;
            idx   <= '0;
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_DIFF;  // table read registered
        S_DIFF: begin
          d[0] <= DiffW'($signed(entry[71:48])) - DiffW'(pos.coord_x);
          d[1] <= DiffW'($signed(entry[47:24])) - DiffW'(pos.coord_y);
          d[2] <= DiffW'($signed(entry[23:0]))  - DiffW'(pos.coord_z);
          sum  <= '0;
          axis <= 2'd0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (axis == 2'd3) begin
            state <= S_ROOT;
          end else begin
            sum  <= sum + SumW'(unsigned'(sq));
            axis <= axis + 2'd1;
          end
        end
        S_ROOT: begin
          if (!ubusy) begin
            range   <= uroot;
            axis    <= 2'd0;
            started <= 1'b0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (range == '0) begin
            jac[0] <= '0; jac[1] <= '0; jac[2] <= '0;
            state  <= S_OUT;
          end else if (!started) begin
            started <= 1'b1;
          end else if (!ubusy) begin
            started <= 1'b0;
            // q <= 32768; positive d gives -q, else q saturated at +32767
            if (!dsel[DiffW-1] && dsel != '0)
              jac[axis] <= JacW'(-uquot);
            else if (uquot[15] || uquot[16])
              jac[axis] <= 16'sh7fff;
            else
              jac[axis] <= JacW'(uquot);
            if (axis == 2'd2) state <= S_OUT;
            else axis <= axis + 2'd1;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data.landmark_index <= 4'(idx);
            out_data.range_mm <= range;
            out_data.jac_x <= jac[0];
            out_data.jac_y <= jac[1];
            out_data.jac_z <= jac[2];
            out_data.degenerate <= (range == '0);
            out_data.last <= (32'(idx) == LANDMARK_COUNT - 1);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            if (32'(idx) == LANDMARK_COUNT - 1) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_WAIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_input_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT)) else $error("result outside output state");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |-> (out_data.jac_x == 0 &&
    out_data.jac_y == 0 && out_data.jac_z == 0)) else $error("degenerate jac");
  a_idle_unit: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ubusy) else $error("unit busy while idle");
`endif

endmodule
